// File: sv/rar_pkg.sv
// rar_pkg: shared constants for the rational arithmetic reduce block.
// Operation codes and fixed result widths; no dependencies.
`default_nettype none

package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RAW_NUM_W         = 33;
  localparam int RAW_DEN_W         = 32;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

endpackage

`default_nettype wire

// File: sv/rar_gcd_step.sv
// rar_gcd_step: one registered step of the binary GCD.
// Carries an opaque sideband along; no package dependencies.
`default_nettype none

module rar_gcd_step #(
  parameter int GW = 33,
  parameter int KW = 6,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [GW-1:0] in_x,
  input  wire logic [GW-1:0] in_y,
  input  wire logic [KW-1:0] in_k,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic      [GW-1:0] out_x,
  output logic      [GW-1:0] out_y,
  output logic      [KW-1:0] out_k,
  output logic      [SW-1:0] out_side
);

  logic          valid_r;
  logic [GW-1:0] x_r, x_nxt;
  logic [GW-1:0] y_r, y_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [SW-1:0] side_r;

  // Each step shortens x, y or both by at least a bit until one of them is zero.
  always_comb begin
    x_nxt = in_x;
    y_nxt = in_y;
    k_nxt = in_k;
    if (in_x != '0 && in_y != '0) begin
      if (!in_x[0] && !in_y[0]) begin
        x_nxt = in_x >> 1;
        y_nxt = in_y >> 1;
        k_nxt = in_k + KW'(1);
      end else if (!in_x[0]) begin
        x_nxt = in_x >> 1;
      end else if (!in_y[0]) begin
        y_nxt = in_y >> 1;
      end else if (in_x >= in_y) begin
        x_nxt = (in_x - in_y) >> 1;
      end else begin
        y_nxt = (in_y - in_x) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      k_r    <= k_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_k     = k_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// File: sv/rar_div_step.sv
// rar_div_step: one quotient bit of two restoring divisions by a shared divisor.
// Dividends shift out MSB first while quotient bits shift in; no package use.
`default_nettype none

module rar_div_step #(
  parameter int GW = 33,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [GW-1:0] in_g,
  input  wire logic [GW-1:0] in_a,
  input  wire logic [GW-1:0] in_b,
  input  wire logic [GW-1:0] in_ra,
  input  wire logic [GW-1:0] in_rb,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic      [GW-1:0] out_g,
  output logic      [GW-1:0] out_a,
  output logic      [GW-1:0] out_b,
  output logic      [GW-1:0] out_ra,
  output logic      [GW-1:0] out_rb,
  output logic      [SW-1:0] out_side
);

  logic          valid_r;
  logic [GW-1:0] g_r, a_r, b_r, ra_r, rb_r;
  logic [SW-1:0] side_r;
  logic [GW:0]   ta, tb;
  logic          qa, qb;
  logic [GW-1:0] a_nxt, b_nxt, ra_nxt, rb_nxt;

  always_comb begin
    ta = {in_ra, in_a[GW-1]};
    tb = {in_rb, in_b[GW-1]};
    qa = (ta >= {1'b0, in_g});
    qb = (tb >= {1'b0, in_g});
    if (qa) ta = ta - {1'b0, in_g};
    if (qb) tb = tb - {1'b0, in_g};
    ra_nxt = ta[GW-1:0];
    rb_nxt = tb[GW-1:0];
    a_nxt  = {in_a[GW-2:0], qa};
    b_nxt  = {in_b[GW-2:0], qb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r    <= in_g;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      ra_r   <= ra_nxt;
      rb_r   <= rb_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_g     = g_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_ra    = ra_r;
  assign out_rb    = rb_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

// File: sv/rational_arith_reduce.sv
// rational_arith_reduce: add/sub/mul/div of two rationals, reduced by their GCD.
// Uses rar_pkg, rar_gcd_step and rar_div_step.
`default_nettype none

//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | mode, a/b numerator and denominator
//  out_    | output    | out_valid/out_stall| raw and reduced fraction, undefined flag
//
// Fully pipelined: one transaction per cycle unless the output is held. GW is
// the internal numerator width (2*OPERAND_WIDTH+1, capped at 64; 33 by default).
// The 2*GW binary GCD steps and GW quotient-bit steps set the depth.
// rst_n clears all valid bits; payload registers are not reset.
// One global enable: while the output register holds an unaccepted transaction
// every stage holds and in_stall is raised.

module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                            [1:0] in_mode,
  input  wire logic signed [OPERAND_WIDTH-1:0]       in_a_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0]       in_a_denominator,
  input  wire logic signed [OPERAND_WIDTH-1:0]       in_b_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0]       in_b_denominator,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [rar_pkg::RAW_NUM_W-1:0]       out_raw_numerator,
  output logic signed [rar_pkg::RAW_DEN_W-1:0]       out_raw_denominator,
  output logic signed [rar_pkg::RAW_NUM_W-1:0]       out_reduced_numerator,
  output logic signed [rar_pkg::RAW_DEN_W-1:0]       out_reduced_denominator,
  output logic                                       out_undefined_flag
);

  import rar_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int NW    = (2 * W + 1 > 64) ? 64 : 2 * W + 1;  // raw numerator width
  localparam int DW    = 2 * W;                               // raw denominator width
  localparam int GW    = NW;                                  // magnitude / GCD width
  localparam int KW    = $clog2(GW + 1);
  localparam int NSTEP = 2 * GW;
  localparam int SWG   = 2 + NW + DW + 2 * GW;
  localparam int SWD   = 3 + NW + DW;

  // Global advance: move every stage unless the output is held.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage 0: capture the transaction.
  logic                v0_r;
  logic [1:0]          mode0_r;
  logic signed [W-1:0] an0_r, ad0_r, bn0_r, bd0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode0_r <= in_mode;
      an0_r   <= in_a_numerator;
      ad0_r   <= in_a_denominator;
      bn0_r   <= in_b_numerator;
      bd0_r   <= in_b_denominator;
    end
  end

  // Stage 1: three cross products, operands picked by the operation.
  logic                  v1_r;
  logic [1:0]            mode1_r;
  logic signed [DW-1:0]  m1_r, m2_r, m3_r;
  logic signed [W-1:0]   m1_op, m3_op;

  assign m1_op = (mode0_r == MODE_MUL) ? bn0_r : bd0_r;
  assign m3_op = (mode0_r == MODE_DIV) ? bn0_r : bd0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r <= mode0_r;
      m1_r    <= an0_r * m1_op;
      m2_r    <= bn0_r * ad0_r;
      m3_r    <= ad0_r * m3_op;
    end
  end

  // Stage 2: combine into the raw fraction and take magnitudes.
  logic                 v2_r;
  logic [1:0]           mode2_r;
  logic signed [NW-1:0] rn_nxt, rn2_r;
  logic signed [DW-1:0] rd2_r;
  logic [GW-1:0]        magn2_r, magd2_r;
  logic [NW-1:0]        magn_nxt;
  logic [DW-1:0]        magd_nxt;

  always_comb begin
    unique case (mode1_r)
      MODE_ADD: rn_nxt = NW'(m1_r) + NW'(m2_r);
      MODE_SUB: rn_nxt = NW'(m1_r) - NW'(m2_r);
      default:  rn_nxt = NW'(m1_r);
    endcase
    magn_nxt = rn_nxt[NW-1] ? NW'(-rn_nxt) : NW'(rn_nxt);
    magd_nxt = m3_r[DW-1] ? DW'(-m3_r) : DW'(m3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode2_r <= mode1_r;
      rn2_r   <= rn_nxt;
      rd2_r   <= m3_r;
      magn2_r <= GW'(magn_nxt);
      magd2_r <= GW'(magd_nxt);
    end
  end

  // Binary GCD chain: 2*GW steps always bring one operand to zero.
  logic           gv [0:NSTEP];
  logic [GW-1:0]  gx [0:NSTEP];
  logic [GW-1:0]  gy [0:NSTEP];
  logic [KW-1:0]  gk [0:NSTEP];
  logic [SWG-1:0] gs [0:NSTEP];

  assign gv[0] = v2_r;
  assign gx[0] = magn2_r;
  assign gy[0] = magd2_r;
  assign gk[0] = '0;
  assign gs[0] = {mode2_r, rn2_r, rd2_r, magn2_r, magd2_r};

  for (genvar i = 0; i < NSTEP; i++) begin : g_gcd
    rar_gcd_step #(.GW(GW), .KW(KW), .SW(SWG)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (gv[i]),
      .in_x     (gx[i]),
      .in_y     (gy[i]),
      .in_k     (gk[i]),
      .in_side  (gs[i]),
      .out_valid(gv[i+1]),
      .out_x    (gx[i+1]),
      .out_y    (gy[i+1]),
      .out_k    (gk[i+1]),
      .out_side (gs[i+1])
    );
  end

  // Restore the common power of two; a zero GCD marks the undefined case.
  logic                 sv_r;
  logic [GW-1:0]        g_r, magn3_r, magd3_r;
  logic                 gz_r;
  logic [1:0]           mode3_r;
  logic signed [NW-1:0] rn3_r;
  logic signed [DW-1:0] rd3_r;
  logic [GW-1:0]        g_nxt;

  assign g_nxt = GW'((gx[NSTEP] | gy[NSTEP]) << gk[NSTEP]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (adv) begin
      sv_r <= gv[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r  <= g_nxt;
      gz_r <= (g_nxt == '0);
      {mode3_r, rn3_r, rd3_r, magn3_r, magd3_r} <= gs[NSTEP];
    end
  end

  // Exact division of both magnitudes by the GCD, one quotient bit per stage.
  logic           dv  [0:GW];
  logic [GW-1:0]  dg  [0:GW];
  logic [GW-1:0]  da  [0:GW];
  logic [GW-1:0]  db  [0:GW];
  logic [GW-1:0]  dra [0:GW];
  logic [GW-1:0]  drb [0:GW];
  logic [SWD-1:0] ds  [0:GW];

  assign dv[0]  = sv_r;
  assign dg[0]  = g_r;
  assign da[0]  = magn3_r;
  assign db[0]  = magd3_r;
  assign dra[0] = '0;
  assign drb[0] = '0;
  assign ds[0]  = {gz_r, mode3_r, rn3_r, rd3_r};

  for (genvar j = 0; j < GW; j++) begin : g_div
    rar_div_step #(.GW(GW), .SW(SWD)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_valid (dv[j]),
      .in_g     (dg[j]),
      .in_a     (da[j]),
      .in_b     (db[j]),
      .in_ra    (dra[j]),
      .in_rb    (drb[j]),
      .in_side  (ds[j]),
      .out_valid(dv[j+1]),
      .out_g    (dg[j+1]),
      .out_a    (da[j+1]),
      .out_b    (db[j+1]),
      .out_ra   (dra[j+1]),
      .out_rb   (drb[j+1]),
      .out_side (ds[j+1])
    );
  end

  // Final stage: reapply signs, normalize the divide-mode denominator, zero an undefined result.
  logic                 fz;
  logic [1:0]           fmode;
  logic signed [NW-1:0] frn, qn_nxt;
  logic signed [DW-1:0] frd, qd_nxt;
  logic                 ov_r, oz_r;
  logic signed [NW-1:0] orn_r, oqn_r;
  logic signed [DW-1:0] ord_r, oqd_r;

  assign {fz, fmode, frn, frd} = ds[GW];

  always_comb begin
    qn_nxt = frn[NW-1] ? NW'(-da[GW]) : NW'(da[GW]);
    qd_nxt = frd[DW-1] ? DW'(-db[GW]) : DW'(db[GW]);
    if (fmode == MODE_DIV && qd_nxt[DW-1]) begin
      qn_nxt = -qn_nxt;
      qd_nxt = -qd_nxt;
    end
    if (fz) begin
      qn_nxt = '0;
      qd_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dv[GW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oz_r  <= fz;
      orn_r <= frn;
      ord_r <= frd;
      oqn_r <= qn_nxt;
      oqd_r <= qd_nxt;
    end
  end

  assign out_valid               = ov_r;
  assign out_raw_numerator       = RAW_NUM_W'(orn_r);
  assign out_raw_denominator     = RAW_DEN_W'(ord_r);
  assign out_reduced_numerator   = RAW_NUM_W'(oqn_r);
  assign out_reduced_denominator = RAW_DEN_W'(oqd_r);
  assign out_undefined_flag      = oz_r;

`ifndef SYNTHESIS
  a_gcd_done: assert property (@(posedge clk) disable iff (!rst_n)
    gv[NSTEP] |-> (gx[NSTEP] == '0 || gy[NSTEP] == '0))
    else $error("GCD chain ended with both operands nonzero");

  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    dv[GW] && !fz |-> (dra[GW] == '0 && drb[GW] == '0))
    else $error("division by GCD left a remainder");

  a_undef_raw: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oz_r |-> (orn_r == '0 && ord_r == '0))
    else $error("undefined flag with nonzero raw fraction");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r && in_stall |=> v0_r && $stable(an0_r) && $stable(mode0_r))
    else $error("input stage changed while pipeline held");
`endif

endmodule

`default_nettype wire
